// ----- sv/psfp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package psfp_pkg;

	localparam int PSFP_FRAME_BYTES = 32;

	localparam logic [7:0] HDR_FIRST  = 8'h32;
	localparam logic [7:0] HDR_SECOND = 8'h3d;
	localparam int         LEN_OVERHEAD = 4;
	localparam int         MIN_END      = 5;
	localparam int         PM_BASE      = 4;

	localparam logic [7:0] SEL_PM2_5 = 8'd1;
	localparam logic [7:0] SEL_PM1_0 = 8'd2;
	localparam logic [7:0] SEL_PM10  = 8'd3;

	typedef struct packed {
		logic        valid;
		logic        good;
		logic [15:0] pm1_0;
		logic [15:0] pm2_5;
		logic [15:0] pm10;
	} frame_sum_t;

endpackage
`default_nettype wire

// ----- sv/psfp_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module psfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- sv/psfp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module psfp_ctrl import psfp_pkg::*; #(
	parameter int FRAME_BYTES = PSFP_FRAME_BYTES
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       res_ready,
	output frame_sum_t      fin
);

	localparam int AW        = $clog2(FRAME_BYTES);
	localparam int CW        = $clog2(FRAME_BYTES + 1);
	localparam int SUM_SPAN  = FRAME_BYTES - 2;
	localparam int FIN_READS = 8;
	localparam int FW        = $clog2(FIN_READS + 1);
	localparam int IW        = $clog2(FIN_READS);

	typedef enum logic [1:0] {ST_IDLE, ST_WR, ST_FIN, ST_DONE} state_t;

	state_t            state_q;
	logic              in_frame_q;
	logic [CW-1:0]     count_q;
	logic [15:0]       len_q;
	logic [15:0]       sum_q;
	logic [FRAME_BYTES-1:0] vld_q;
	logic [AW-1:0]     wr_addr_s1;
	logic [7:0]        wr_data_s1;
	logic              end_s1;
	logic              rd_vld_s1;
	logic [FW-1:0]     fin_cnt_q;
	logic [7:0]        fin_b_q [FIN_READS];

	logic              acc;
	logic              acc_we;
	logic [AW-1:0]     acc_addr;
	logic              nxt_in_frame;
	logic [CW-1:0]     nxt_count;
	logic [15:0]       nxt_len;
	logic              nxt_end;
	logic [CW-1:0]     inc_count;
	logic [AW-1:0]     fin_addr;
	logic [AW-1:0]     raddr;
	logic [7:0]        rdata;
	logic [7:0]        old_byte;
	logic [IW-1:0]     cap_idx;
	logic              ram_we;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;
	assign inc_count = count_q + CW'(1);

	always_comb begin
		acc_we       = 1'b0;
		acc_addr     = '0;
		nxt_in_frame = in_frame_q;
		nxt_count    = count_q;
		nxt_len      = len_q;
		nxt_end      = 1'b0;
		if (!in_frame_q) begin
			if (count_q == CW'(0)) begin
				if (rx_byte == HDR_FIRST) begin
					acc_we    = 1'b1;
					acc_addr  = AW'(0);
					nxt_count = CW'(1);
				end
			end else if (count_q == CW'(1)) begin
				if (rx_byte == HDR_SECOND) begin
					acc_we       = 1'b1;
					acc_addr     = AW'(1);
					nxt_count    = CW'(2);
					nxt_in_frame = 1'b1;
				end else begin
					nxt_count = '0;
				end
			end else begin
				nxt_count = '0;
			end
		end else begin
			acc_we    = 1'b1;
			acc_addr  = count_q[AW-1:0];
			nxt_count = inc_count;
			if (inc_count == CW'(3)) begin
				nxt_len = {8'd0, rx_byte};
			end else if (inc_count == CW'(4)) begin
				nxt_len = {len_q[7:0], rx_byte};
			end else if (inc_count >= CW'(MIN_END)) begin
				if ({{(17 - CW){1'b0}}, inc_count} >= ({1'b0, len_q} + 17'(LEN_OVERHEAD))
				    || inc_count >= CW'(FRAME_BYTES)) begin
					nxt_end      = 1'b1;
					nxt_in_frame = 1'b0;
					nxt_count    = '0;
				end
			end
		end
	end

	assign fin_addr = (fin_cnt_q < FW'(2)) ? AW'(SUM_SPAN + int'(fin_cnt_q))
	                                       : AW'(int'(fin_cnt_q) + PM_BASE - 2);
	assign raddr    = (state_q == ST_IDLE) ? acc_addr : fin_addr;
	assign old_byte = rd_vld_s1 ? rdata : 8'd0;
	assign cap_idx  = IW'(fin_cnt_q - FW'(1));
	assign ram_we   = (state_q == ST_WR);

	psfp_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr_s1),
		.wdata (wr_data_s1),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		rd_vld_s1 <= vld_q[raddr];
		if (acc) begin
			wr_addr_s1 <= acc_addr;
			wr_data_s1 <= rx_byte;
			end_s1     <= nxt_end;
		end
		if (state_q == ST_FIN && fin_cnt_q != FW'(0)) begin
			fin_b_q[cap_idx] <= old_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_frame_q <= 1'b0;
			count_q    <= '0;
			len_q      <= '0;
			sum_q      <= '0;
			vld_q      <= '0;
			fin_cnt_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						in_frame_q <= nxt_in_frame;
						count_q    <= nxt_count;
						len_q      <= nxt_len;
						if (acc_we) begin
							state_q <= ST_WR;
						end
					end
				end
				ST_WR: begin
					vld_q[wr_addr_s1] <= 1'b1;
					if (wr_addr_s1 < AW'(SUM_SPAN)) begin
						sum_q <= sum_q + {8'd0, wr_data_s1} - {8'd0, old_byte};
					end
					fin_cnt_q <= '0;
					state_q   <= end_s1 ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					if (fin_cnt_q == FW'(FIN_READS)) begin
						state_q <= ST_DONE;
					end else begin
						fin_cnt_q <= fin_cnt_q + FW'(1);
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign fin.valid = (state_q == ST_DONE);
	assign fin.good  = (sum_q == {fin_b_q[0], fin_b_q[1]});
	assign fin.pm1_0 = {fin_b_q[2], fin_b_q[3]};
	assign fin.pm2_5 = {fin_b_q[4], fin_b_q[5]};
	assign fin.pm10  = {fin_b_q[6], fin_b_q[7]};

endmodule
`default_nettype wire

// ----- sv/psfp_result.sv -----
`timescale 1ns / 1ps
`default_nettype none
module psfp_result import psfp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire frame_sum_t  fin,
	output logic             res_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             frame_good,
	output logic [15:0]      pm1_0_value,
	output logic [15:0]      pm2_5_value,
	output logic [15:0]      pm10_value,
	output logic [15:0]      chosen_value
);

	logic [7:0] sel_q;
	logic       out_valid_q;
	logic       good_q;
	logic [15:0] pm1_0_q;
	logic [15:0] pm2_5_q;
	logic [15:0] pm10_q;
	logic [15:0] choice_q;
	logic        load;

	assign res_ready = !out_valid_q || out_ready;
	assign load      = fin.valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= SEL_PM2_5;
			out_valid_q <= 1'b0;
			good_q      <= 1'b0;
			pm1_0_q     <= '0;
			pm2_5_q     <= '0;
			pm10_q      <= '0;
			choice_q    <= '0;
		end else begin
			if (cfg_we) begin
				sel_q <= cfg_wdata;
			end
			if (load) begin
				out_valid_q <= 1'b1;
				good_q      <= fin.good;
				if (fin.good) begin
					pm1_0_q <= fin.pm1_0;
					pm2_5_q <= fin.pm2_5;
					pm10_q  <= fin.pm10;
					priority if (sel_q == SEL_PM2_5) begin
						choice_q <= fin.pm2_5;
					end else if (sel_q == SEL_PM1_0) begin
						choice_q <= fin.pm1_0;
					end else if (sel_q == SEL_PM10) begin
						choice_q <= fin.pm10;
					end else begin
						choice_q <= choice_q;
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_good   = good_q;
	assign pm1_0_value  = pm1_0_q;
	assign pm2_5_value  = pm2_5_q;
	assign pm10_value   = pm10_q;
	assign chosen_value = choice_q;

endmodule
`default_nettype wire

// ----- sv/pm_sensor_frame_parser.sv -----
// A dropped header byte leaves the parser idle; a stored byte goes from idle (read of the
// old buffer byte) to the write state (write-back with the running checksum update).
// Frame end: after the frame's last byte is stored, the checksum and the readings are
// read back byte by byte from the buffer and passed to the registered result stage.
// Input: one dropped byte per cycle while idle; none in write-back, read-back or result wait.
// Reset (arst_n, async): hunting, buffer reads as zero, readings 0, value_select 1.
`timescale 1ns / 1ps
`default_nettype none
module pm_sensor_frame_parser import psfp_pkg::*; #(
	parameter int FRAME_BYTES = PSFP_FRAME_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             frame_good,
	output logic [15:0]      pm1_0_value,
	output logic [15:0]      pm2_5_value,
	output logic [15:0]      pm10_value,
	output logic [15:0]      chosen_value
);

	frame_sum_t fin;
	logic       res_ready;

	psfp_ctrl #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.res_ready (res_ready),
		.fin       (fin)
	);

	psfp_result u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.fin          (fin),
		.res_ready    (res_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_good   (frame_good),
		.pm1_0_value  (pm1_0_value),
		.pm2_5_value  (pm2_5_value),
		.pm10_value   (pm10_value),
		.chosen_value (chosen_value)
	);

endmodule
`default_nettype wire

// ----- sv/psfp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module psfp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        frame_good,
	input wire logic [15:0] pm1_0_value,
	input wire logic [15:0] pm2_5_value,
	input wire logic [15:0] pm10_value,
	input wire logic [15:0] chosen_value
);

	// a new result only comes out of the read-back, when no byte is taken
	a_result_after_readback: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while input was open");

	// a rejected frame leaves every reading as it was
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && !frame_good |-> $stable(pm1_0_value) && $stable(pm2_5_value)
		&& $stable(pm10_value) && $stable(chosen_value))
		else $error("readings changed on a rejected frame");

	// the PM2.5 reading only moves together with a shown good result
	a_change_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(pm2_5_value) |-> out_valid && frame_good)
		else $error("reading changed without a good result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_good)
		&& $stable(chosen_value))
		else $error("stalled item changed");

endmodule

bind pm_sensor_frame_parser psfp_checker u_psfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.frame_good   (frame_good),
	.pm1_0_value  (pm1_0_value),
	.pm2_5_value  (pm2_5_value),
	.pm10_value   (pm10_value),
	.chosen_value (chosen_value)
);
`default_nettype wire
